[rtl/swin_pkg.sv]
// Package of shared types and constants for the separable image window.
package swin_pkg;

    localparam int COORD_W    = 10;
    localparam int SAMPLE_W   = 8;
    localparam int WEIGHTED_W = 24;
    localparam int MODE_W     = 3;
    localparam int LOG2_W     = 4;
    localparam int CFG_DATA_W = 4;
    localparam int WEIGHT_W   = 17;
    localparam int PH_BITS    = 20;
    localparam int DIV_NUM_W  = COORD_W + 1 + PH_BITS;
    localparam int HORNER_STEPS = 7;
    localparam int COS_LAT    = 2 + 3 * HORNER_STEPS + 1;
    localparam int LANE_LAT   = 1 + DIV_NUM_W + COS_LAT + 2;

    localparam logic CFG_WINDOW_MODE = 1'b0;
    localparam logic CFG_LOG2_SIZE   = 1'b1;

    localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HANN     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HAMMING  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLACKMAN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TAPER    = 3'd4;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_NONE;
    localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd10;

    localparam logic [31:0] TWO_PI_LO = 32'd2451551556;
    localparam logic [29:0] C054 = 30'd579820585;
    localparam logic [29:0] C046 = 30'd493921239;
    localparam logic [29:0] C050 = 30'd536870912;
    localparam logic [29:0] C042 = 30'd450971566;
    localparam logic [29:0] C008 = 30'd85899346;
    localparam logic [WEIGHT_W-1:0] W_ONE = 17'd65536;

    localparam logic [7:0] HORNER_M [HORNER_STEPS] = '{
        8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };
    localparam logic [31:0] HORNER_R [HORNER_STEPS] = '{
        32'd23598721, 32'd32537631, 32'd47721858, 32'd76695844,
        32'd143165576, 32'd357913941, 32'd2147483648
    };

    typedef struct packed {
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [SAMPLE_W-1:0] sample;
    } swin_req_t;

    typedef struct packed {
        logic [WEIGHTED_W-1:0] weighted;
        logic                  coord_error;
    } swin_res_t;

endpackage

[rtl/separable_2d_image_window.sv]
// Top level of the separable two-dimensional image window.
//
// A request carries a column, a row and a grayscale sample. It is taken at a
// rising edge where start is high and busy is low; busy never rises, so one
// request can be taken in every cycle.
// Each request produces one result: the sample times the window weight of
// its column and of its row, in unsigned Q8.16, with coord_error set and the
// value zero when a coordinate lies outside the configured grid.
// The result appears on result for one cycle with done high. On its way it
// passes through the 31-stage phase divider, the seven-step cosine series at
// three stages a step, and the window and product stages; results leave in
// request order. The receiver cannot hold results off and nothing inside
// waits on it. Configuration is written through cfg_we, cfg_index and
// cfg_wdata; the user must do so only while no request is in flight, which
// the block does not enforce. Reset clears all valid bits and sets the
// window mode to none and log2_size to ten.
module separable_2d_image_window #(
    parameter int MAX_LOG2_SIZE = 10,
    parameter int SAMPLE_BITS   = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  swin_pkg::swin_req_t               req,
    output logic                              done,
    output swin_pkg::swin_res_t               result,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [swin_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int S_W = (SAMPLE_BITS < swin_pkg::SAMPLE_W) ? SAMPLE_BITS : swin_pkg::SAMPLE_W;
    localparam int SIZE_W = MAX_LOG2_SIZE + 1;
    localparam int LAT = swin_pkg::LANE_LAT;
    localparam int TOTAL_LAT = LAT + 2;
    localparam int WW = swin_pkg::WEIGHT_W;
    localparam int PROD_W = S_W + 2 * WW + 1;

    logic [swin_pkg::MODE_W-1:0] mode_reg;
    logic [swin_pkg::LOG2_W-1:0] log2_reg;
    logic                        accept;
    logic [swin_pkg::LOG2_W-1:0] lg;
    logic [SIZE_W-1:0]           size;
    logic                        err_in;

    logic           vld_line [LAT];
    logic           err_line [LAT];
    logic [S_W-1:0] smp_line [LAT];

    logic [WW-1:0]     wc;
    logic [WW-1:0]     wr;
    logic [S_W+WW-1:0] sw_reg;
    logic [WW-1:0]     wr_reg;
    logic              f1_vld_reg;
    logic              f1_err_reg;
    logic [PROD_W-1:0] prod;
    logic              done_reg;
    swin_pkg::swin_res_t result_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= swin_pkg::MODE_RESET;
            log2_reg <= swin_pkg::LOG2_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swin_pkg::CFG_WINDOW_MODE: mode_reg <= cfg_wdata[swin_pkg::MODE_W-1:0];
                swin_pkg::CFG_LOG2_SIZE:   log2_reg <= cfg_wdata[swin_pkg::LOG2_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        lg     = (log2_reg > swin_pkg::LOG2_W'(MAX_LOG2_SIZE)) ?
                 swin_pkg::LOG2_W'(MAX_LOG2_SIZE) : log2_reg;
        size   = SIZE_W'(1) << lg;
        err_in = ({{SIZE_W{1'b0}}, req.col} >= {{swin_pkg::COORD_W{1'b0}}, size}) ||
                 ({{SIZE_W{1'b0}}, req.row} >= {{swin_pkg::COORD_W{1'b0}}, size});
    end

    swin_lane #(.MAX_LOG2_SIZE(MAX_LOG2_SIZE)) u_lane_col (
        .clk (clk), .n (req.col), .mode (mode_reg), .log2_size (log2_reg), .weight (wc)
    );
    swin_lane #(.MAX_LOG2_SIZE(MAX_LOG2_SIZE)) u_lane_row (
        .clk (clk), .n (req.row), .mode (mode_reg), .log2_size (log2_reg), .weight (wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_line[i] <= 1'b0;
            end
            f1_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_line[i] <= (i == 0) ? accept : vld_line[(i == 0) ? 0 : i - 1];
            end
            f1_vld_reg <= vld_line[LAT-1];
            done_reg   <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LAT; i++)
        begin
            err_line[i] <= (i == 0) ? err_in : err_line[(i == 0) ? 0 : i - 1];
            smp_line[i] <= (i == 0) ? req.sample[S_W-1:0] : smp_line[(i == 0) ? 0 : i - 1];
        end
        sw_reg     <= smp_line[LAT-1] * wc;
        wr_reg     <= wr;
        f1_err_reg <= err_line[LAT-1];
        result_reg.coord_error <= f1_err_reg;
        result_reg.weighted    <= f1_err_reg ? '0 : swin_pkg::WEIGHTED_W'(prod >> 16);
    end

    assign prod   = PROD_W'(sw_reg) * PROD_W'(wr_reg) + PROD_W'(32768);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("result strobe without a matching request");

    a_error_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.coord_error) |-> (result.weighted == '0))
        else $error("coordinate error with a non-zero result");

    a_weight_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({8'd0, result.weighted} <=
                  ({24'd0, $past(req.sample, TOTAL_LAT)} << 16)))
        else $error("result exceeds the sample value");
`endif

endmodule

[rtl/swin_div.sv]
// Pipelined restoring divider that keeps the low quotient bits.
module swin_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 10,
    parameter int Q_W   = 20
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [Q_W-1:0]   q_reg   [NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   q_in;
        logic [DEN_W:0]   trial;
        logic             take;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign num_in = num_reg[i-1];
            assign den_in = den_reg[i-1];
            assign q_in   = q_reg[i-1];
        end

        assign trial = {rem_in, num_in[NUM_W-1-i]};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
            num_reg[i] <= num_in;
            den_reg[i] <= den_in;
            q_reg[i]   <= {q_in[Q_W-2:0], take};
        end
    end

    assign quot = q_reg[NUM_W-1];

endmodule

[rtl/swin_cos.sv]
// Pipelined fixed-point cosine of a phase in turns, Q30 result.
module swin_cos (
    input  logic                          clk,
    input  logic [swin_pkg::PH_BITS-1:0]  phase,
    output logic signed [31:0]            cos_q30
);

    localparam int STEPS = swin_pkg::HORNER_STEPS;

    logic [1:0]  quad;
    logic [18:0] f;
    logic [50:0] f_lo;
    logic [51:0] r_sum;
    logic [30:0] r_reg;
    logic        neg_a_reg;
    logic [61:0] sq;
    logic [31:0] r2_reg;
    logic        neg_b_reg;

    logic signed [31:0] t_reg   [STEPS];
    logic [31:0]        r2_out  [STEPS];
    logic               neg_out [STEPS];
    logic signed [31:0] cos_reg;

    assign quad  = phase[19:18];
    assign f     = quad[0] ? (19'h40000 - {1'b0, phase[17:0]}) : {1'b0, phase[17:0]};
    assign f_lo  = f * swin_pkg::TWO_PI_LO;
    assign r_sum = {1'b0, f, 32'd0} + {1'b0, f_lo} + 52'd524288;
    assign sq    = r_reg * r_reg + 62'd536870912;

    always_ff @(posedge clk)
    begin
        r_reg     <= r_sum[50:20];
        neg_a_reg <= quad[1] ^ quad[0];
        r2_reg    <= sq[61:30];
        neg_b_reg <= neg_a_reg;
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        logic signed [31:0] t_in;
        logic [31:0]        r2_in;
        logic               neg_in;
        logic [62:0]        prod;
        logic [31:0]        p_reg;
        logic [31:0]        r2_s1_reg;
        logic               neg_s1_reg;
        logic [63:0]        qm_reg;
        logic [31:0]        p2_reg;
        logic [31:0]        r2_s2_reg;
        logic               neg_s2_reg;
        logic [31:0]        q0;
        logic [39:0]        rem;
        logic [31:0]        q;

        if (j == 0) begin : g_first
            assign t_in   = 32'sd1073741824;
            assign r2_in  = r2_reg;
            assign neg_in = neg_b_reg;
        end
        else begin : g_next
            assign t_in   = t_reg[j-1];
            assign r2_in  = r2_out[j-1];
            assign neg_in = neg_out[j-1];
        end

        assign prod = r2_in * t_in[30:0];
        assign q0   = qm_reg[63:32];
        assign rem  = {8'd0, p2_reg} - q0 * swin_pkg::HORNER_M[j];
        assign q    = q0 + 32'(rem >= {32'd0, swin_pkg::HORNER_M[j]});

        always_ff @(posedge clk)
        begin
            p_reg      <= prod[61:30];
            r2_s1_reg  <= r2_in;
            neg_s1_reg <= neg_in;
            qm_reg     <= p_reg * swin_pkg::HORNER_R[j];
            p2_reg     <= p_reg;
            r2_s2_reg  <= r2_s1_reg;
            neg_s2_reg <= neg_s1_reg;
            t_reg[j]   <= 32'sd1073741824 - $signed(q);
            r2_out[j]  <= r2_s2_reg;
            neg_out[j] <= neg_s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= neg_out[STEPS-1] ? -t_reg[STEPS-1] : t_reg[STEPS-1];
    end

    assign cos_q30 = cos_reg;

endmodule

[rtl/swin_lane.sv]
// One-dimensional window weight for one coordinate, Q1.16.
module swin_lane #(
    parameter int MAX_LOG2_SIZE = 10
) (
    input  logic                            clk,
    input  logic [swin_pkg::COORD_W-1:0]    n,
    input  logic [swin_pkg::MODE_W-1:0]     mode,
    input  logic [swin_pkg::LOG2_W-1:0]     log2_size,
    output logic [swin_pkg::WEIGHT_W-1:0]   weight
);

    localparam int SIZE_W = MAX_LOG2_SIZE + 1;
    localparam int DEN_W  = MAX_LOG2_SIZE;
    localparam int NUM_W  = swin_pkg::DIV_NUM_W;
    localparam int PH     = swin_pkg::PH_BITS;
    localparam int SIDE_LAT = NUM_W + swin_pkg::COS_LAT;

    typedef struct packed {
        logic                        force_one;
        logic [swin_pkg::MODE_W-1:0] mode;
    } side_t;

    logic [swin_pkg::LOG2_W-1:0] lg;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] border;
    logic [SIZE_W-1:0] n_ext;
    logic [SIZE_W-1:0] far;
    logic [SIZE_W-1:0] d_full;
    logic [DEN_W-1:0]  den_tri;
    logic [NUM_W-1:0]  num_tri1;
    logic [NUM_W-1:0]  num_tri2;
    logic [NUM_W-1:0]  num_tap;
    logic [NUM_W-1:0]  num1_next;
    logic [DEN_W-1:0]  den_next;
    side_t             side_next;

    logic [NUM_W-1:0]  num1_reg;
    logic [NUM_W-1:0]  num2_reg;
    logic [DEN_W-1:0]  den_reg;
    side_t             side_reg;
    side_t             side_line [SIDE_LAT];

    logic [PH-1:0]      ph1;
    logic [PH-1:0]      ph2;
    logic signed [31:0] c1;
    logic signed [31:0] c2;

    logic [29:0]        coef_a;
    logic [29:0]        coef_b;
    logic signed [62:0] p1_next;
    logic signed [62:0] p2_next;
    logic [29:0]        base_reg;
    logic signed [62:0] p1_reg;
    logic signed [62:0] p2_reg;
    logic               force_w_reg;
    logic signed [63:0] w60;
    logic [63:0]        w_round;
    logic [swin_pkg::WEIGHT_W-1:0] weight_next;
    logic [swin_pkg::WEIGHT_W-1:0] weight_reg;

    always_comb
    begin
        lg       = (log2_size > swin_pkg::LOG2_W'(MAX_LOG2_SIZE)) ?
                   swin_pkg::LOG2_W'(MAX_LOG2_SIZE) : log2_size;
        size     = SIZE_W'(1) << lg;
        border   = size >> 5;
        n_ext    = SIZE_W'(n);
        far      = size - SIZE_W'(1) - n_ext;
        d_full   = (far < n_ext) ? far : n_ext;
        den_tri  = DEN_W'(size - SIZE_W'(1));
        num_tri1 = (NUM_W'(n) << PH) + NUM_W'(den_tri >> 1);
        num_tri2 = (NUM_W'(n) << (PH + 1)) + NUM_W'(den_tri >> 1);
        num_tap  = (NUM_W'(swin_pkg::COORD_W'(d_full)) << PH) + NUM_W'(border);
        side_next.mode = mode;
        unique case (mode)
            swin_pkg::MODE_HANN, swin_pkg::MODE_HAMMING, swin_pkg::MODE_BLACKMAN:
            begin
                side_next.force_one = (lg == '0);
                num1_next = num_tri1;
                den_next  = den_tri;
            end
            swin_pkg::MODE_TAPER:
            begin
                side_next.force_one = (border == '0) || (d_full >= border);
                num1_next = num_tap;
                den_next  = DEN_W'(size >> 4);
            end
            default:
            begin
                side_next.force_one = 1'b1;
                num1_next = num_tri1;
                den_next  = den_tri;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        num1_reg <= num1_next;
        num2_reg <= num_tri2;
        den_reg  <= den_next;
        side_reg <= side_next;
        for (int i = 0; i < SIDE_LAT; i++)
        begin
            side_line[i] <= (i == 0) ? side_reg : side_line[(i == 0) ? 0 : i - 1];
        end
    end

    swin_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(PH)) u_div1 (
        .clk (clk), .num (num1_reg), .den (den_reg), .quot (ph1)
    );
    swin_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(PH)) u_div2 (
        .clk (clk), .num (num2_reg), .den (den_reg), .quot (ph2)
    );
    swin_cos u_cos1 (.clk (clk), .phase (ph1), .cos_q30 (c1));
    swin_cos u_cos2 (.clk (clk), .phase (ph2), .cos_q30 (c2));

    always_comb
    begin
        unique case (side_line[SIDE_LAT-1].mode)
            swin_pkg::MODE_HANN:
            begin
                coef_a = swin_pkg::C050;
                coef_b = swin_pkg::C050;
            end
            swin_pkg::MODE_BLACKMAN:
            begin
                coef_a = swin_pkg::C042;
                coef_b = swin_pkg::C050;
            end
            default:
            begin
                coef_a = swin_pkg::C054;
                coef_b = swin_pkg::C046;
            end
        endcase
        p1_next = $signed({1'b0, coef_b}) * c1;
        p2_next = (side_line[SIDE_LAT-1].mode == swin_pkg::MODE_BLACKMAN) ?
                  $signed({1'b0, swin_pkg::C008}) * c2 : 63'sd0;
    end

    always_ff @(posedge clk)
    begin
        base_reg    <= coef_a;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        force_w_reg <= side_line[SIDE_LAT-1].force_one;
        weight_reg  <= weight_next;
    end

    always_comb
    begin
        w60     = $signed({4'd0, base_reg, 30'd0}) - 64'(p1_reg) + 64'(p2_reg);
        w_round = $unsigned(w60) + 64'h0000_0800_0000_0000;
        if (force_w_reg)
        begin
            weight_next = swin_pkg::W_ONE;
        end
        else if (w60[63])
        begin
            weight_next = '0;
        end
        else
        begin
            weight_next = w_round[44 +: swin_pkg::WEIGHT_W];
        end
    end

    assign weight = weight_reg;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the separable two-dimensional image window.
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 80;
    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    swin_pkg::swin_req_t req = '0;
    logic done;
    swin_pkg::swin_res_t result;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [swin_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [swin_pkg::MODE_W-1:0] cur_mode = swin_pkg::MODE_RESET;
    logic [swin_pkg::LOG2_W-1:0] cur_log2 = swin_pkg::LOG2_RESET;
    swin_pkg::swin_res_t pending_products[$];
    int error_count = 0;
    int request_count = 0;
    int result_count = 0;
    int setting_count = 0;
    int cycle_count = 0;

    separable_2d_image_window dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic longint cos_of_turn(int unsigned p);
        int unsigned quad;
        int unsigned f;
        longint unsigned r;
        longint unsigned r2;
        longint t;
        longint m;
        p = p & 32'hFFFFF;
        quad = (p >> 18) & 3;
        f = p & 32'h3FFFF;
        if (quad & 1)
        begin
            f = 32'h40000 - f;
        end
        r = (longint'(f) * TWO_PI_Q30 + (64'd1 << 19)) >> 20;
        r2 = (r * r + (64'd1 << 29)) >> 30;
        t = ONE_Q30;
        for (int k = 7; k >= 1; k--)
        begin
            m = (2 * k - 1) * (2 * k);
            t = ONE_Q30 - (longint'(r2) * t) / (m * ONE_Q30);
        end
        if (quad == 1 || quad == 2)
        begin
            t = -t;
        end
        return t;
    endfunction

    function automatic int unsigned turn_phase(longint unsigned num, longint unsigned den);
        return int'(((num << 20) + den / 2) / den) & 32'hFFFFF;
    endfunction

    function automatic longint unsigned round_q16(longint w60);
        if (w60 < 0)
        begin
            return 0;
        end
        return (longint'(w60) + (64'd1 << 43)) >> 44;
    endfunction

    function automatic longint unsigned axis_weight(logic [swin_pkg::MODE_W-1:0] mode,
                                                    int unsigned n, int unsigned size);
        longint c1;
        longint c2;
        int unsigned border;
        int unsigned d;
        if (mode == swin_pkg::MODE_HANN || mode == swin_pkg::MODE_HAMMING ||
            mode == swin_pkg::MODE_BLACKMAN)
        begin
            if (size <= 1)
            begin
                return swin_pkg::W_ONE;
            end
            c1 = cos_of_turn(turn_phase(n, size - 1));
            if (mode == swin_pkg::MODE_HANN)
            begin
                return round_q16(longint'(swin_pkg::C050) * ONE_Q30
                                 - longint'(swin_pkg::C050) * c1);
            end
            if (mode == swin_pkg::MODE_HAMMING)
            begin
                return round_q16(longint'(swin_pkg::C054) * ONE_Q30
                                 - longint'(swin_pkg::C046) * c1);
            end
            c2 = cos_of_turn(turn_phase(longint'(n) * 2, size - 1));
            return round_q16(longint'(swin_pkg::C042) * ONE_Q30
                             - longint'(swin_pkg::C050) * c1
                             + longint'(swin_pkg::C008) * c2);
        end
        if (mode == swin_pkg::MODE_TAPER)
        begin
            border = size >> 5;
            d = n;
            if (size - 1 - n < d)
            begin
                d = size - 1 - n;
            end
            if (border == 0 || d >= border)
            begin
                return swin_pkg::W_ONE;
            end
            c1 = cos_of_turn(turn_phase(d, longint'(border) * 2));
            return round_q16(longint'(swin_pkg::C054) * ONE_Q30
                             - longint'(swin_pkg::C046) * c1);
        end
        return swin_pkg::W_ONE;
    endfunction

    function automatic swin_pkg::swin_res_t windowed_pixel(swin_pkg::swin_req_t r);
        swin_pkg::swin_res_t res;
        int unsigned lg;
        int unsigned size;
        longint unsigned wc;
        longint unsigned wr;
        lg = (cur_log2 > 10) ? 10 : cur_log2;
        size = 1 << lg;
        res = '0;
        if (r.col >= size || r.row >= size)
        begin
            res.coord_error = 1'b1;
            return res;
        end
        wc = axis_weight(cur_mode, r.col, size);
        wr = axis_weight(cur_mode, r.row, size);
        res.weighted = swin_pkg::WEIGHTED_W'((longint'(r.sample) * wc * wr
                                              + (64'd1 << 15)) >> 16);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endtask

    always @(posedge clk)
    begin
        swin_pkg::swin_res_t want;
        if (rst_n && done)
        begin
            result_count++;
            if (pending_products.size() == 0)
            begin
                report_mismatch("unexpected result", result.weighted, 0);
            end
            else
            begin
                want = pending_products.pop_front();
                if (result.weighted !== want.weighted)
                begin
                    report_mismatch("weighted", result.weighted, want.weighted);
                end
                if (result.coord_error !== want.coord_error)
                begin
                    report_mismatch("coord_error", result.coord_error, want.coord_error);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send_request(logic [swin_pkg::COORD_W-1:0] col,
                                logic [swin_pkg::COORD_W-1:0] row,
                                logic [swin_pkg::SAMPLE_W-1:0] sample);
        int gap;
        start <= 1'b1;
        req <= '{col: col, row: row, sample: sample};
        do @(posedge clk); while (busy);
        pending_products.push_back(windowed_pixel('{col: col, row: row, sample: sample}));
        request_count++;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_products.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_setting(logic [swin_pkg::MODE_W-1:0] mode,
                                 logic [swin_pkg::LOG2_W-1:0] lg);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= swin_pkg::CFG_WINDOW_MODE;
        cfg_wdata <= {1'($urandom_range(0, 1)), mode};
        @(posedge clk);
        cfg_index <= swin_pkg::CFG_LOG2_SIZE;
        cfg_wdata <= lg;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_mode = mode;
        cur_log2 = lg;
        setting_count++;
    endtask

    task automatic test_directed();
        write_setting(swin_pkg::MODE_NONE, 4'd10);
        send_request(10'd0, 10'd0, 8'd0);
        send_request(10'd1023, 10'd1023, 8'd255);
        for (int m = 1; m < 8; m++)
        begin
            write_setting(m[swin_pkg::MODE_W-1:0], 4'd10);
            send_request(10'd0, 10'd1023, 8'd255);
            send_request(10'd511, 10'd512, 8'd255);
            send_request(10'd17, 10'd1010, 8'd200);
        end
        write_setting(swin_pkg::MODE_HANN, 4'd0);
        send_request(10'd0, 10'd0, 8'd255);
        send_request(10'd1, 10'd0, 8'd255);
        write_setting(swin_pkg::MODE_TAPER, 4'd4);
        send_request(10'd0, 10'd15, 8'd255);
        write_setting(swin_pkg::MODE_BLACKMAN, 4'd15);
        send_request(10'd1023, 10'd300, 8'd128);
    endtask

    function automatic logic [swin_pkg::COORD_W-1:0] pick_coord(int unsigned size);
        int unsigned border;
        border = size >> 5;
        if ($urandom_range(0, 9) == 0)
        begin
            return swin_pkg::COORD_W'($urandom_range(0, 1023));
        end
        if (border > 0 && $urandom_range(0, 2) == 0)
        begin
            return swin_pkg::COORD_W'($urandom_range(0, 1) ? $urandom_range(0, border)
                                      : size - 1 - $urandom_range(0, border));
        end
        return swin_pkg::COORD_W'($urandom_range(0, size - 1));
    endfunction

    task automatic test_random_settings();
        logic [swin_pkg::LOG2_W-1:0] lg;
        int unsigned size;
        int count;
        for (int phase = 0; phase < 20; phase++)
        begin
            case (phase % 5)
                0: lg = 4'd10;
                1: lg = 4'd0;
                2: lg = swin_pkg::LOG2_W'($urandom_range(11, 15));
                default: lg = swin_pkg::LOG2_W'($urandom_range(1, 10));
            endcase
            write_setting(swin_pkg::MODE_W'(phase % 8), lg);
            size = 1 << ((lg > 10) ? 10 : lg);
            count = (phase % 5 == 0) ? 45 : 28;
            for (int i = 0; i < count; i++)
            begin
                send_request(pick_coord(size), pick_coord(size),
                             swin_pkg::SAMPLE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_settings();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests under %0d register settings and checked %0d results.",
                 request_count, setting_count, result_count);
        $display("Every window mode code and grid sizes from one up to clamped were exercised.");
        if (error_count == 0 && pending_products.size() == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing.", error_count,
                     pending_products.size());
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
